>>> hw/rtl/ctkg_pkg.sv
// shared types, constants and helpers for the three-key color gradient
`default_nettype none

package ctkg_pkg;

   // field widths
   localparam int LIFE_W     = 16;
   localparam int RND_W      = 32;
   localparam int CH_W       = 16;
   localparam int COLOR_W    = 3 * CH_W;
   localparam int PCT_W      = 7;
   localparam int BOUNDS_W   = 3 * PCT_W;
   localparam int REPS_W     = 8;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // random start offset
   localparam int RANDOM_SHIFT = 6;
   localparam int OFS_W        = RND_W - RANDOM_SHIFT;
   localparam int SUM_W        = ((OFS_W > LIFE_W) ? OFS_W : LIFE_W) + 1;

   // percent to bound: x / 100 == (x * ceil(2^30 / 100)) >> 30 for x < 2^23
   localparam int X_W             = PCT_W + LIFE_W;
   localparam int BND_W           = LIFE_W + 1;
   localparam int PCT_RECIP_SHIFT = 30;
   localparam logic [23:0] PCT_RECIP = 24'd10737419;
   localparam int PROD_W          = X_W + 24;

   // pipeline stage map
   localparam int ST_ENT = 0;
   localparam int ST_D1  = ST_ENT + 1;
   localparam int ST_PER = ST_D1 + LIFE_W;
   localparam int ST_MOD = ST_PER + 1;
   localparam int ST_X   = ST_MOD + SUM_W;
   localparam int ST_B   = ST_X + 1;
   localparam int ST_SEL = ST_B + 1;
   localparam int ST_DIF = ST_SEL + 1;
   localparam int ST_MUL = ST_DIF + 1;
   localparam int ST_D2  = ST_MUL + 1;
   localparam int ST_OUT = ST_D2 + CH_W;
   localparam int NSTG   = ST_OUT + 1;

   // register map, index is paddr[5:3]
   typedef enum logic [2:0] {
      REG_REPEAT_COUNT   = 3'd0,
      REG_RANDOM_START   = 3'd1,
      REG_SECTION_BOUNDS = 3'd2,
      REG_COLOR_FIRST    = 3'd3,
      REG_COLOR_MIDDLE   = 3'd4,
      REG_COLOR_LAST     = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [REPS_W-1:0]   repeat_count;
      logic                random_start;
      logic [BOUNDS_W-1:0] section_bounds;
      logic [COLOR_W-1:0]  color_first;
      logic [COLOR_W-1:0]  color_middle;
      logic [COLOR_W-1:0]  color_last;
   } cfg_type;

   // one pipeline slot; each stage updates the fields it owns
   typedef struct packed {
      logic [LIFE_W-1:0]          life;
      logic [REPS_W-1:0]          reps;
      logic [LIFE_W-1:0]          q1;
      logic [REPS_W-1:0]          r1;
      logic [SUM_W-1:0]           sum;
      logic [LIFE_W-1:0]          period;
      logic                       pzero;
      logic [LIFE_W-1:0]          r2;
      logic [2:0][X_W-1:0]        x;
      logic [2:0][BND_W-1:0]      b;
      logic [COLOR_W-1:0]         from;
      logic [COLOR_W-1:0]         to;
      logic [LIFE_W-1:0]          off;
      logic [BND_W-1:0]           span;
      logic [2:0]                 neg;
      logic [2:0][CH_W-1:0]       absd;
      logic [2:0][BND_W-1:0]      r3;
      logic [2:0][CH_W-1:0]       qs;
      logic [2:0][CH_W-1:0]       res;
   } pipe_type;

   // channel c of a packed color: red, green, blue
   function automatic logic [CH_W-1:0] chan_of(input logic [COLOR_W-1:0] pk,
                                                input logic [1:0] c);
      logic [CH_W-1:0] v;
      case (c)
         2'd0:    v = pk[3*CH_W-1:2*CH_W];
         2'd1:    v = pk[2*CH_W-1:CH_W];
         default: v = pk[CH_W-1:0];
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ctkg_req_if.sv
// particle input channel
`default_nettype none

interface ctkg_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] lifetime;
   logic [15:0] age;
   logic [31:0] random_word;

   modport source (output valid, output lifetime, output age, output random_word,
                   input ready);
   modport sink (input valid, input lifetime, input age, input random_word,
                 output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ctkg_rsp_if.sv
// color result channel
`default_nettype none

interface ctkg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] red;
   logic signed [15:0] green;
   logic signed [15:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ctkg_csr.sv
// apb-style configuration register file
`default_nettype none

module ctkg_csr import ctkg_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type     cfg_ff;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:3]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff              <= '0;
         cfg_ff.repeat_count <= REPS_W'(1);
      end else if (wr_en) begin
         unique case (idx)
            REG_REPEAT_COUNT:   cfg_ff.repeat_count   <= pwdata[REPS_W-1:0];
            REG_RANDOM_START:   cfg_ff.random_start   <= pwdata[0];
            REG_SECTION_BOUNDS: cfg_ff.section_bounds <= pwdata[BOUNDS_W-1:0];
            REG_COLOR_FIRST:    cfg_ff.color_first    <= pwdata[COLOR_W-1:0];
            REG_COLOR_MIDDLE:   cfg_ff.color_middle   <= pwdata[COLOR_W-1:0];
            REG_COLOR_LAST:     cfg_ff.color_last     <= pwdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (idx)
         REG_REPEAT_COUNT:   prdata = CSR_DATA_W'(cfg_ff.repeat_count);
         REG_RANDOM_START:   prdata = CSR_DATA_W'(cfg_ff.random_start);
         REG_SECTION_BOUNDS: prdata = CSR_DATA_W'(cfg_ff.section_bounds);
         REG_COLOR_FIRST:    prdata = CSR_DATA_W'(cfg_ff.color_first);
         REG_COLOR_MIDDLE:   prdata = CSR_DATA_W'(cfg_ff.color_middle);
         REG_COLOR_LAST:     prdata = CSR_DATA_W'(cfg_ff.color_last);
         default:            prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/color_three_key_gradient_core.sv
// throughput: one transaction per cycle when not stalled; one restoring-divide step
//    per stage in the period, wrap and three-lane ramp dividers sets the depth, not the rate
// the whole pipeline stalls together only while the result register holds an untaken result
// reset: synchronous, clears all valid bits; repeat_count resets to 1, other config registers to 0
`default_nettype none

module color_three_key_gradient_core import ctkg_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ctkg_req_if.sink                   req_chan,
   ctkg_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type          cfg;
   logic [NSTG-1:0]  vld_ff;
   pipe_type         stg_ff [NSTG];
   pipe_type         stg_in [NSTG];
   logic             adv;

   ctkg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // global advance: move unless the result register holds an untaken transaction
   assign adv            = ~vld_ff[NSTG-1] | rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage logic
   for (genvar g = 0; g < NSTG; g++) begin : g_stg
      if (g == ST_ENT) begin : g_ent
         always_comb begin
            logic [OFS_W-1:0] ofs;
            ofs = cfg.random_start ? OFS_W'(req_chan.random_word >> RANDOM_SHIFT) : '0;
            stg_in[g]      = '0;
            stg_in[g].life = req_chan.lifetime;
            stg_in[g].reps = (cfg.repeat_count == '0) ? REPS_W'(1) : cfg.repeat_count;
            stg_in[g].q1   = req_chan.lifetime;
            stg_in[g].sum  = SUM_W'(req_chan.age) + SUM_W'(ofs);
         end
      end else begin : g_step
         always_comb begin
            pipe_type              s;
            pipe_type              n;
            logic [REPS_W:0]       t9;
            logic [LIFE_W:0]       t17;
            logic [BND_W:0]        t18;
            logic                  ge;
            logic [PROD_W-1:0]     prod;
            logic [BND_W-1:0]      pos;
            logic signed [CH_W:0]  d;
            logic [CH_W:0]         ad;
            logic [2*CH_W-1:0]     mag;
            logic [CH_W-1:0]       fc;
            logic [CH_W-1:0]       tc;
            s    = stg_ff[g-1];
            n    = s;
            t9   = '0;
            t17  = '0;
            t18  = '0;
            ge   = 1'b0;
            prod = '0;
            pos  = '0;
            d    = '0;
            ad   = '0;
            mag  = '0;
            fc   = '0;
            tc   = '0;
            if (g < ST_PER) begin
               // period = lifetime / repeats, one quotient bit per stage
               t9   = {s.r1, s.q1[LIFE_W-1]};
               ge   = (t9 >= {1'b0, s.reps});
               t9   = ge ? (t9 - {1'b0, s.reps}) : t9;
               n.r1 = t9[REPS_W-1:0];
               n.q1 = {s.q1[LIFE_W-2:0], ge};
            end else if (g == ST_PER) begin
               // fall back to the whole life when the split gives zero
               n.period = (s.q1 == '0) ? s.life : s.q1;
               n.pzero  = (s.life == '0);
               n.r2     = '0;
            end else if (g < ST_X) begin
               // wrap the age to the period, one dividend bit per stage
               t17   = {s.r2, s.sum[SUM_W-1]};
               ge    = (t17 >= {1'b0, s.period});
               t17   = ge ? (t17 - {1'b0, s.period}) : t17;
               n.r2  = t17[LIFE_W-1:0];
               n.sum = {s.sum[SUM_W-2:0], ge};
            end else if (g == ST_X) begin
               // percent times period
               for (int k = 0; k < 3; k++) begin
                  n.x[k] = X_W'(cfg.section_bounds[PCT_W*k +: PCT_W]) * X_W'(s.period);
               end
            end else if (g == ST_B) begin
               // divide by one hundred through the reciprocal
               for (int k = 0; k < 3; k++) begin
                  prod   = PROD_W'(s.x[k]) * PROD_W'(PCT_RECIP);
                  n.b[k] = prod[PCT_RECIP_SHIFT +: BND_W];
               end
            end else if (g == ST_SEL) begin
               // section choice; constant sections run as a zero ramp
               pos    = {1'b0, s.r2};
               n.off  = '0;
               n.span = BND_W'(1);
               if (s.pzero || pos < s.b[0]) begin
                  n.from = cfg.color_first;
                  n.to   = cfg.color_first;
               end else if (pos < s.b[1]) begin
                  n.from = cfg.color_first;
                  n.to   = cfg.color_middle;
                  n.off  = LIFE_W'(pos - s.b[0]);
                  n.span = s.b[1] - s.b[0];
               end else if (pos < s.b[2]) begin
                  n.from = cfg.color_middle;
                  n.to   = cfg.color_last;
                  n.off  = LIFE_W'(pos - s.b[1]);
                  n.span = s.b[2] - s.b[1];
               end else begin
                  n.from = cfg.color_last;
                  n.to   = cfg.color_last;
               end
            end else if (g == ST_DIF) begin
               // key difference, split into sign and magnitude
               for (int c = 0; c < 3; c++) begin
                  fc        = chan_of(s.from, 2'(c));
                  tc        = chan_of(s.to, 2'(c));
                  d         = $signed({tc[CH_W-1], tc}) - $signed({fc[CH_W-1], fc});
                  ad        = d[CH_W] ? ((CH_W+1)'(0) - d) : d;
                  n.neg[c]  = d[CH_W];
                  n.absd[c] = ad[CH_W-1:0];
               end
            end else if (g == ST_MUL) begin
               // magnitude times offset; high half seeds the remainder
               for (int c = 0; c < 3; c++) begin
                  mag     = (2*CH_W)'(s.absd[c]) * (2*CH_W)'(s.off);
                  n.r3[c] = {1'b0, mag[2*CH_W-1:CH_W]};
                  n.qs[c] = mag[CH_W-1:0];
               end
            end else if (g < ST_OUT) begin
               // ramp division, one quotient bit per stage in three lanes
               for (int c = 0; c < 3; c++) begin
                  t18     = {s.r3[c], s.qs[c][CH_W-1]};
                  ge      = (t18 >= {1'b0, s.span});
                  t18     = ge ? (t18 - {1'b0, s.span}) : t18;
                  n.r3[c] = t18[BND_W-1:0];
                  n.qs[c] = {s.qs[c][CH_W-2:0], ge};
               end
            end else begin
               // key plus signed quotient, truncated to the channel width
               for (int c = 0; c < 3; c++) begin
                  fc       = chan_of(s.from, 2'(c));
                  n.res[c] = s.neg[c] ? (fc - s.qs[c]) : (fc + s.qs[c]);
               end
            end
            stg_in[g] = n;
         end
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_chan.valid};
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         stg_ff <= stg_in;
      end
   end

   // result channel
   assign rsp_chan.valid = vld_ff[NSTG-1];
   assign rsp_chan.red   = stg_ff[NSTG-1].res[0];
   assign rsp_chan.green = stg_ff[NSTG-1].res[1];
   assign rsp_chan.blue  = stg_ff[NSTG-1].res[2];

endmodule

`default_nettype wire
